// ----- sv/pli_pkg.sv -----
package pli_pkg;

   localparam int PLI_CAPACITY = 16;
   localparam int DATA_W       = 32;
   localparam int POS_W        = 5;
   localparam int LEN_W        = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_DUMP   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // What every cell of the chain does in the current cycle.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   // Command broadcast along the chain.
   typedef struct packed {
      cell_op_type              op;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ----- sv/pli_if.sv -----
interface pli_req_if
   import pli_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic signed [DATA_W-1:0] value;
   logic [POS_W-1:0]         position;

   modport source (output valid, output opcode, output value, output position, input ready);
   modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface pli_rsp_if
   import pli_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic signed [DATA_W-1:0] value_res;
   logic                     last;
   logic [LEN_W-1:0]         length;

   modport source (output valid, output status, output value_res, output last, output length,
                   input ready);
   modport sink   (input valid, input status, input value_res, input last, input length,
                   output ready);
endinterface

// ----- sv/pli_cell.sv -----
module pli_cell
   import pli_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  cell_cmd_type             cmd,
   input  logic                     is_tail,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   input  logic signed [DATA_W-1:0] head_data,
   output logic signed [DATA_W-1:0] data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   // Insert opens a gap at the position, delete closes it, and rotate moves the
   // head entry round to the tail so that the list streams out from cell zero.
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (INDEX > int'(cmd.pos)) begin
               data_in = left_data;
            end else if (INDEX == int'(cmd.pos)) begin
               data_in = cmd.value;
            end
         end
         CELL_DELETE: begin
            if (INDEX >= int'(cmd.pos)) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            data_in = is_tail ? head_data : right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- sv/positional_list_insert_delete.sv -----
// Channel  Modport  Word carried
// req_if   sink     opcode, value, position
// rsp_if   source   status, value_res, last, length
//
// Insert and delete work as every cell of the chain shifts or holds at once; a
// new word may follow as soon as the output register is free.
// A dump of n entries first accepts the word, then gives one result word a cycle,
// unless the result channel stalls, as the chain rotates the head out through cell zero.
// Reset clears the entry count and the control state; cell contents stay as
// they are and are never read before they have been written.
// A stall on the result channel freezes the chain and holds the output register.
module positional_list_insert_delete
   import pli_pkg::*;
#(
   parameter int CAPACITY = PLI_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   pli_req_if.sink    req_if,
   pli_rsp_if.source  rsp_if
);

   // Count must hold CAPACITY itself; comparisons with the position use the
   // wider of the count and position widths.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]         rsp_length_ff, rsp_length_in;

   cell_cmd_type             cmd;
   logic signed [DATA_W-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]      tail_sel;

   logic                     out_free;
   logic                     accept;
   logic [CMP_W-1:0]         pos_w;
   logic [CMP_W-1:0]         count_w;
   logic                     dump_last;

   // The chain of cells. Cell zero has no left neighbour and the top cell no
   // right neighbour; those inputs are never selected in a way that matters.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_w;
      logic signed [DATA_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = cell_data[i];
      end else begin : g_mid_left
         assign left_w = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign right_w = cell_data[i];
      end else begin : g_mid_right
         assign right_w = cell_data[i+1];
      end

      assign tail_sel[i] = (count_ff == CNT_W'(i + 1));

      pli_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .is_tail    (tail_sel[i]),
         .left_data  (left_w),
         .right_data (right_w),
         .head_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   // The output register can take a new word when it is empty or being drained.
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE) && out_free;
   assign accept       = req_if.valid && req_if.ready;

   assign pos_w     = CMP_W'(req_if.position);
   assign count_w   = CMP_W'(count_ff);
   assign dump_last = (idx_ff == CNT_W'(count_ff - 1'b1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_length_in = rsp_length_ff;
      cmd.op        = CELL_HOLD;
      cmd.pos       = req_if.position;
      cmd.value     = req_if.value;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Single-word results all carry a zero value and the last mark.
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_length_in = LEN_W'(count_ff);
               case (req_if.opcode)
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (pos_w > count_w) begin
                        rsp_status_in = ST_RANGE;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        cmd.op        = CELL_INSERT;
                        count_in      = CNT_W'(count_ff + 1'b1);
                        rsp_status_in = ST_OK;
                        rsp_length_in = LEN_W'(count_ff + 1'b1);
                     end
                  end
                  OP_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (pos_w >= count_w) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        cmd.op        = CELL_DELETE;
                        count_in      = CNT_W'(count_ff - 1'b1);
                        rsp_status_in = ST_OK;
                        rsp_length_in = LEN_W'(count_ff - 1'b1);
                     end
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        state_in = S_DUMP;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                     // The unused opcode is dropped without a result.
                     rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
                  end
               endcase
            end
         end
         S_DUMP: begin
            // Cell zero always holds the next entry; after count rotations the
            // list is back in its original order.
            if (out_free) begin
               cmd.op        = CELL_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = cell_data[0];
               rsp_last_in   = dump_last;
               rsp_length_in = LEN_W'(count_ff);
               idx_in        = CNT_W'(idx_ff + 1'b1);
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.value_res = rsp_value_ff;
   assign rsp_if.last      = rsp_last_ff;
   assign rsp_if.length    = rsp_length_ff;

endmodule

// ----- verif/pli_list_check_pkg.sv -----
package pli_list_check_pkg;
   import pli_pkg::*;

   // One result word as the block should present it.
   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] value_res;
      logic                     last;
      logic [LEN_W-1:0]         length;
   } list_result_type;

   class ListMirror;
      logic signed [DATA_W-1:0] cells [PLI_CAPACITY];
      int unsigned              fill;
      list_result_type          awaited_words [$];
      int unsigned              mismatches;

      int unsigned n_insert, n_delete, n_dump, n_ignored;
      int unsigned n_range, n_full, n_empty, n_checked, peak_fill;

      function new();
         fill = 0;
         mismatches = 0;
         n_insert = 0;
         n_delete = 0;
         n_dump = 0;
         n_ignored = 0;
         n_range = 0;
         n_full = 0;
         n_empty = 0;
         n_checked = 0;
         peak_fill = 0;
      endfunction

      function int unsigned pending();
         return awaited_words.size();
      endfunction

      function void queue_result(status_type st, logic signed [DATA_W-1:0] v, logic lst,
                                 int unsigned len);
         list_result_type r;
         r.status    = st;
         r.value_res = v;
         r.last      = lst;
         r.length    = len[LEN_W-1:0];
         awaited_words.push_back(r);
      endfunction

      // Updates the mirrored list for one accepted request word.
      function void note_word(logic [1:0] opcode, logic signed [DATA_W-1:0] value,
                              logic [POS_W-1:0] position);
         int unsigned pos;
         pos = position;
         case (opcode)
            OP_INSERT: begin
               n_insert++;
               if (pos > fill) begin
                  n_range++;
                  queue_result(ST_RANGE, '0, 1'b1, fill);
               end else if (fill >= PLI_CAPACITY) begin
                  n_full++;
                  queue_result(ST_FULL, '0, 1'b1, fill);
               end else begin
                  for (int i = fill; i > pos; i--)
                     cells[i] = cells[i-1];
                  cells[pos] = value;
                  fill++;
                  if (fill > peak_fill)
                     peak_fill = fill;
                  queue_result(ST_OK, '0, 1'b1, fill);
               end
            end
            OP_DELETE: begin
               n_delete++;
               if (pos >= fill) begin
                  n_range++;
                  queue_result(ST_RANGE, '0, 1'b1, fill);
               end else begin
                  for (int i = pos; i + 1 < fill; i++)
                     cells[i] = cells[i+1];
                  fill--;
                  queue_result(ST_OK, '0, 1'b1, fill);
               end
            end
            OP_DUMP: begin
               n_dump++;
               if (fill == 0) begin
                  n_empty++;
                  queue_result(ST_EMPTY, '0, 1'b1, 0);
               end else begin
                  for (int i = 0; i < fill; i++)
                     queue_result(ST_OK, cells[i], (i + 1 == fill), fill);
               end
            end
            default: n_ignored++;
         endcase
      endfunction

      task flag_mismatch(string msg);
         mismatches++;
         $display("MISMATCH: %s", msg);
      endtask

      // Compares one accepted result word with the oldest one awaited.
      task check_word(logic [1:0] status, logic signed [DATA_W-1:0] value_res, logic last,
                      logic [LEN_W-1:0] length);
         list_result_type want;
         if (awaited_words.size() == 0) begin
            flag_mismatch($sformatf("result word %0d arrived with nothing awaited", n_checked));
            n_checked++;
            return;
         end
         want = awaited_words.pop_front();
         if (status !== want.status)
            flag_mismatch($sformatf("word %0d status %0d, wanted %0d",
                                    n_checked, status, want.status));
         if (value_res !== want.value_res)
            flag_mismatch($sformatf("word %0d value_res %0d, wanted %0d",
                                    n_checked, value_res, want.value_res));
         if (last !== want.last)
            flag_mismatch($sformatf("word %0d last %b, wanted %b", n_checked, last, want.last));
         if (length !== want.length)
            flag_mismatch($sformatf("word %0d length %0d, wanted %0d",
                                    n_checked, length, want.length));
         n_checked++;
      endtask
   endclass

endpackage

// ----- verif/tb_positional_list_insert_delete.sv -----
module tb_positional_list_insert_delete;
   timeunit 1ns;
   timeprecision 1ps;

   import pli_pkg::*;
   import pli_list_check_pkg::*;

   // Opcode 3 has no meaning in the block and must be swallowed without a result word.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Cycles with no word moving on either channel before the run is declared hung.
   // The longest legitimate quiet spell is a long sender gap or receiver stall,
   // far shorter than this limit, so this leaves a wide margin.
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_WORDS = 320;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh80000000;

   logic clock;
   logic reset;

   pli_req_if req_if ();
   pli_rsp_if rsp_if ();

   positional_list_insert_delete dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   ListMirror mirror = new();

   // When set, the sender issues words back to back with no gaps at all.
   logic steady_send;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Gap lengths: mostly none or short, now and then a long one, so that pauses
   // land on every phase of an insert, a delete and a streaming dump.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 40);
   endfunction

   // Values lean towards the signed extremes, zero and minus one.
   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return VAL_MAX;
      else if (r < 16)
         return VAL_MIN;
      else if (r < 22)
         return -1;
      else if (r < 28)
         return 0;
      else
         return $urandom();
   endfunction

   // Presents one request word, waits for the handshake and records it with the
   // mirror. Valid is only lowered if a gap follows, so a back-to-back word keeps
   // it high without a second assignment in the same time step.
   task automatic send_word(input logic [1:0] opcode, input logic signed [DATA_W-1:0] value,
                            input logic [POS_W-1:0] position);
      int gap;
      req_if.valid    <= 1'b1;
      req_if.opcode   <= opcode;
      req_if.value    <= value;
      req_if.position <= position;
      do
         @(posedge clock);
      while (req_if.ready !== 1'b1);
      mirror.note_word(opcode, value, position);
      gap = steady_send ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender back until every awaited result word has been seen. The
   // task always waits for the clock before it checks, so the lowered valid settles
   // before the next word is presented.
   task automatic drain_results();
      do
         @(posedge clock);
      while (mirror.pending() != 0);
   endtask

   // Result side back-pressure: runs of ready, some of them long, broken by stalls.
   initial begin
      int run;
      int stall;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
         rsp_if.ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Every accepted result word is checked at the edge that moves it.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         mirror.check_word(rsp_if.status, rsp_if.value_res, rsp_if.last, rsp_if.length);
   end

   // Watchdog: counts cycles in which no word moves on either channel.
   initial begin
      int idle;
      idle = 0;
      @(negedge reset);
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            idle = 0;
         else
            idle++;
      end
      $display("Watchdog expired after %0d quiet cycles.", IDLE_LIMIT);
      $display("positional_list_insert_delete verification failed");
      $finish;
   end

   initial begin
      int issued;
      int r;
      bit filling;
      logic [1:0] op;
      logic [POS_W-1:0] pos;

      // All block inputs are known from the very first instant.
      steady_send     = 1'b0;
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.opcode   <= OP_INSERT;
      req_if.value    <= '0;
      req_if.position <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The empty list first: a dump gives the single empty word,
      // and a delete or an insert beyond the end is refused.
      send_word(OP_DUMP, pick_value(), 5'd0);
      send_word(OP_DELETE, 0, 5'd0);
      send_word(OP_INSERT, 123, 5'd1);
      // Extreme values at the head, the tail and the head again.
      send_word(OP_INSERT, VAL_MAX, 5'd0);
      send_word(OP_INSERT, VAL_MIN, 5'd2 - 5'd1);
      send_word(OP_INSERT, -1, 5'd0);
      // Far out of range, with every position bit set.
      send_word(OP_INSERT, 7, 5'd31);
      // Deleting one place past the end must be flagged rather than obeyed.
      send_word(OP_DELETE, 0, 5'd3);
      // The unused opcode must leave no trace.
      send_word(OP_UNUSED, VAL_MIN, 5'd1);
      send_word(OP_DELETE, 0, 5'd1);
      send_word(OP_DUMP, 0, 5'd0);
      // Fill to capacity at random places, then push against the full list: a
      // valid position reports full, an invalid one reports the range first.
      while (mirror.fill < PLI_CAPACITY)
         send_word(OP_INSERT, pick_value(), POS_W'($urandom_range(0, mirror.fill)));
      send_word(OP_INSERT, 55, POS_W'($urandom_range(0, PLI_CAPACITY)));
      send_word(OP_INSERT, 56, POS_W'(PLI_CAPACITY + 1));
      send_word(OP_DELETE, 0, POS_W'(PLI_CAPACITY));
      send_word(OP_DUMP, 0, 5'd0);

      // Let the block fall completely quiet before the random part starts.
      req_if.valid <= 1'b0;
      drain_results();

      // Random part. The list drifts between empty and full so that every length
      // is visited; most words are valid inserts and deletes with random content,
      // the rest are dumps, out-of-range positions and the odd unused opcode.
      issued  = 0;
      filling = 1'b0;
      while (issued < RANDOM_WORDS) begin
         if (mirror.fill == PLI_CAPACITY)
            filling = 1'b0;
         else if (mirror.fill == 0)
            filling = 1'b1;
         else if ($urandom_range(0, 49) == 0)
            filling = !filling;

         steady_send = (issued >= 200 && issued < 260);
         if (issued == 175) begin
            req_if.valid <= 1'b0;
            drain_results();
         end

         r = $urandom_range(0, 99);
         if (r < 3) begin
            op  = OP_UNUSED;
            pos = POS_W'($urandom());
         end else if (r < 13) begin
            op  = OP_DUMP;
            pos = POS_W'($urandom());
         end else if (r < 20) begin
            op  = $urandom_range(0, 1) ? OP_INSERT : OP_DELETE;
            pos = POS_W'($urandom());
         end else begin
            if (mirror.fill == 0)
               op = OP_INSERT;
            else if (mirror.fill == PLI_CAPACITY)
               op = ($urandom_range(0, 3) == 0) ? OP_INSERT : OP_DELETE;
            else if (filling)
               op = ($urandom_range(0, 3) != 0) ? OP_INSERT : OP_DELETE;
            else
               op = ($urandom_range(0, 3) != 0) ? OP_DELETE : OP_INSERT;
            // Valid positions, leaning towards the two ends of the list.
            r = $urandom_range(0, 3);
            if (op == OP_INSERT)
               pos = (r == 0) ? POS_W'(0) : (r == 1) ? POS_W'(mirror.fill)
                                                     : POS_W'($urandom_range(0, mirror.fill));
            else
               pos = (r == 0) ? POS_W'(0) : (r == 1) ? POS_W'(mirror.fill - 1)
                                                     : POS_W'($urandom_range(0, mirror.fill - 1));
         end
         send_word(op, pick_value(), pos);
         if (op != OP_UNUSED)
            issued++;
      end
      steady_send = 1'b0;
      req_if.valid <= 1'b0;

      // Wait for the last awaited word, then go on clocking to catch any stray words.
      drain_results();
      repeat (20) @(posedge clock);
      if (mirror.pending() != 0)
         mirror.flag_mismatch($sformatf("%0d result words never arrived", mirror.pending()));

      $display("Covered %0d inserts, %0d deletes, %0d dumps and %0d ignored words; %0d %s",
               mirror.n_insert, mirror.n_delete, mirror.n_dump, mirror.n_ignored,
               mirror.n_checked, "result words checked.");
      $display("Refusals: %0d out of range, %0d full, %0d empty dumps; peak length %0d.",
               mirror.n_range, mirror.n_full, mirror.n_empty, mirror.peak_fill);
      if (mirror.mismatches == 0)
         $display("positional_list_insert_delete verification clean");
      else
         $display("positional_list_insert_delete verification failed");
      $finish;
   end

endmodule
